>>> rtl/core/isd_pkg.sv
// Shared types, constants and field widths for the IMU smoothing decimator.
`timescale 1ns / 1ps

package isd_pkg;

    localparam int ISD_RING_DEPTH = 8;
    localparam int ISD_LANES      = 6;

    localparam int ISD_WORD_W  = 16;
    localparam int ISD_TIME_W  = 32;
    localparam int ISD_SLOT_W  = 3;
    localparam int ISD_GAIN_W  = 17;
    localparam int ISD_EVERY_W = 8;
    localparam int ISD_ACC_W   = 34;

    localparam int ISD_S_TDATA_W = 144;
    localparam int ISD_M_TDATA_W = 152;
    localparam int ISD_CFG_IDX_W = 2;

    localparam logic [ISD_GAIN_W-1:0] ISD_GAIN_ONE   = 17'd32768;
    localparam logic [ISD_GAIN_W-1:0] ISD_GAIN_RST   = 17'd5000;
    localparam logic [ISD_WORD_W-1:0] ISD_PERIOD_RST = 16'd20;
    localparam logic [ISD_EVERY_W-1:0] ISD_EVERY_RST = 8'd5;

    localparam logic signed [ISD_ACC_W-1:0] ISD_ROUND_HALF = 34'sd16384;
    localparam logic signed [ISD_ACC_W-1:0] ISD_ACC_MAX    = 34'sh0_3fff_ffff;
    localparam logic signed [ISD_ACC_W-1:0] ISD_ACC_MIN    = -34'sh0_4000_0000;

    typedef enum logic [ISD_CFG_IDX_W-1:0] {
        ISD_CFG_GAIN   = 2'd0,
        ISD_CFG_PERIOD = 2'd1,
        ISD_CFG_EVERY  = 2'd2
    } isd_cfg_t;

    // Poll decision for one accepted request.
    typedef struct packed {
        logic                  fire;
        logic                  strobe;
        logic [ISD_SLOT_W-1:0] slot;
    } isd_poll_t;

endpackage

>>> rtl/core/isd_lane.sv
// One Q15 first-order smoothing lane holding its channel value.
`timescale 1ns / 1ps

module isd_lane
    import isd_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         update,
    input  logic        [ISD_GAIN_W-1:0] gain,
    input  logic        [ISD_GAIN_W-1:0] gain_comp,
    input  logic signed [ISD_WORD_W-1:0] sample,
    output logic signed [ISD_WORD_W-1:0] value_next
);

    logic signed [ISD_WORD_W-1:0] value_reg;
    logic signed [ISD_GAIN_W:0]   gain_s;
    logic signed [ISD_GAIN_W:0]   comp_s;
    logic signed [ISD_ACC_W-1:0]  prod_new;
    logic signed [ISD_ACC_W-1:0]  prod_old;
    logic signed [ISD_ACC_W-1:0]  acc;
    logic signed [ISD_ACC_W-1:0]  acc_sat;

    assign gain_s   = {1'b0, gain};
    assign comp_s   = {1'b0, gain_comp};
    assign prod_new = sample * gain_s;
    assign prod_old = value_reg * comp_s;
    assign acc      = prod_new + prod_old + ISD_ROUND_HALF;

    always_comb begin
        priority if (acc > ISD_ACC_MAX) begin
            acc_sat = ISD_ACC_MAX;
        end else if (acc < ISD_ACC_MIN) begin
            acc_sat = ISD_ACC_MIN;
        end else begin
            acc_sat = acc;
        end
    end

    // Saturated range fits 31 bits, so the arithmetic shift is a part-select.
    assign value_next = update ? acc_sat[30:15] : value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

endmodule

>>> rtl/core/isd_poll.sv
// Poll timing, decimation counter and ring slot index.
`timescale 1ns / 1ps

module isd_poll
    import isd_pkg::*;
#(
    parameter int RING_DEPTH = ISD_RING_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [ISD_WORD_W-1:0]  time_lo,
    input  logic [ISD_WORD_W-1:0]  period,
    input  logic [ISD_EVERY_W-1:0] store_every,
    output isd_poll_t              poll
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

    logic [ISD_WORD_W-1:0]  last_reg,  last_next;
    logic [ISD_EVERY_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]      slot_reg,  slot_next;
    logic [ISD_WORD_W-1:0]  elapsed;
    logic [ISD_EVERY_W-1:0] count_inc;
    logic                   fire;
    logic                   strobe;
    logic [SLOT_W+ISD_SLOT_W-1:0] slot_ext;

    assign elapsed   = time_lo - last_reg;
    assign fire      = (elapsed >= period);
    assign count_inc = count_reg + 1'b1;
    assign strobe    = fire && (count_inc >= store_every);

    always_comb begin
        last_next  = last_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        if (accept && fire) begin
            last_next  = last_reg + period;
            count_next = strobe ? '0 : count_inc;
            if (strobe) begin
                slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    assign slot_ext    = {{ISD_SLOT_W{1'b0}}, slot_next};
    assign poll.fire   = fire;
    assign poll.strobe = strobe;
    assign poll.slot   = slot_ext[ISD_SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            count_reg <= '0;
            slot_reg  <= '0;
        end else begin
            last_reg  <= last_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

>>> rtl/core/isd_merge.sv
// Merge stage: combine lane values, held temperature and poll status into the result.
`timescale 1ns / 1ps

module isd_merge
    import isd_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic                         frame_ok,
    input  logic        [ISD_WORD_W-1:0] temp_raw,
    input  logic        [ISD_TIME_W-1:0] stamp,
    input  isd_poll_t                    poll,
    input  logic signed [ISD_WORD_W-1:0] lane_value [ISD_LANES],
    output logic                         s_ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic      [ISD_M_TDATA_W-1:0] m_tdata,
    output logic                         m_tuser
);

    logic                      valid_reg, valid_next;
    logic [ISD_M_TDATA_W-1:0]  data_reg;
    logic                      user_reg;
    logic [ISD_WORD_W-1:0]     temp_reg, temp_next;
    logic                      load;

    assign s_ready   = !valid_reg || m_tready;
    assign load      = accept && poll.fire;
    assign temp_next = (load && frame_ok) ? temp_raw : temp_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            temp_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            temp_reg  <= temp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {5'b0, stamp, poll.slot, temp_next,
                         lane_value[5], lane_value[4], lane_value[3],
                         lane_value[2], lane_value[1], lane_value[0]};
            user_reg <= poll.strobe;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

>>> rtl/core/imu_six_axis_smoothing_decimator.sv
// Top level of the six-axis IMU smoothing decimator.
//
//  channel   dir  handshake               payload
//  s_        in   s_tvalid / s_tready     s_tdata (time, 3 accel, temp, 3 gyro), s_tuser (frame ok)
//  m_        out  m_tvalid / m_tready     m_tdata (6 smoothed, temp, slot, stamp), m_tuser (store)
//  cfg_      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per cycle while s_tready is high; a poll result appears in the cycle after its request is accepted.
// The six lane multipliers and the poll compare close within the accept cycle.
// aresetn is synchronous, active low, and restores the default register values.
// While a result waits on m_tready low, s_tready is held low; cfg_ready is always high.
`timescale 1ns / 1ps

module imu_six_axis_smoothing_decimator
    import isd_pkg::*;
#(
    parameter int RING_DEPTH = ISD_RING_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // time_ms, accel_x, accel_y, accel_z, temp_raw, gyro_x, gyro_y, gyro_z
    input  logic [ISD_S_TDATA_W-1:0]  s_tdata,
    // frame_ok
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // smooth_ax, smooth_ay, smooth_az, smooth_gx, smooth_gy, smooth_gz,
    // temp_held, ring_slot, stamp_ms, zero pad
    output logic [ISD_M_TDATA_W-1:0]  m_tdata,
    // store_strobe
    output logic                      m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ISD_CFG_IDX_W-1:0]  cfg_index,
    input  logic [ISD_WORD_W-1:0]     cfg_data
);

    logic [ISD_GAIN_W-1:0]  gain_reg,   gain_next;
    logic [ISD_GAIN_W-1:0]  comp_reg,   comp_next;
    logic [ISD_WORD_W-1:0]  period_reg, period_next;
    logic [ISD_EVERY_W-1:0] every_reg,  every_next;
    logic [ISD_GAIN_W-1:0]  gain_clip;

    logic                         accept;
    logic                         update;
    isd_poll_t                    poll;
    logic signed [ISD_WORD_W-1:0] sample     [ISD_LANES];
    logic signed [ISD_WORD_W-1:0] lane_value [ISD_LANES];

    assign cfg_ready = 1'b1;
    assign gain_clip = (cfg_data > ISD_GAIN_ONE[ISD_WORD_W-1:0] && cfg_data != '0)
                       ? ISD_GAIN_ONE : {1'b0, cfg_data};

    // Hold the gain clipped and its complement precomputed.
    always_comb begin
        gain_next   = gain_reg;
        comp_next   = comp_reg;
        period_next = period_reg;
        every_next  = every_reg;
        if (cfg_valid) begin
            unique case (isd_cfg_t'(cfg_index))
                ISD_CFG_GAIN: begin
                    gain_next = gain_clip;
                    comp_next = ISD_GAIN_ONE - gain_clip;
                end
                ISD_CFG_PERIOD: period_next = cfg_data;
                ISD_CFG_EVERY:  every_next  = cfg_data[ISD_EVERY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= ISD_GAIN_RST;
            comp_reg   <= ISD_GAIN_ONE - ISD_GAIN_RST;
            period_reg <= ISD_PERIOD_RST;
            every_reg  <= ISD_EVERY_RST;
        end else begin
            gain_reg   <= gain_next;
            comp_reg   <= comp_next;
            period_reg <= period_next;
            every_reg  <= every_next;
        end
    end

    assign accept = s_tvalid && s_tready;
    assign update = accept && poll.fire && s_tuser;

    assign sample[0] = s_tdata[47:32];
    assign sample[1] = s_tdata[63:48];
    assign sample[2] = s_tdata[79:64];
    assign sample[3] = s_tdata[111:96];
    assign sample[4] = s_tdata[127:112];
    assign sample[5] = s_tdata[143:128];

    isd_poll #(
        .RING_DEPTH (RING_DEPTH)
    ) u_poll (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .time_lo     (s_tdata[15:0]),
        .period      (period_reg),
        .store_every (every_reg),
        .poll        (poll)
    );

    for (genvar i = 0; i < ISD_LANES; i++) begin : g_lane
        isd_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .update     (update),
            .gain       (gain_reg),
            .gain_comp  (comp_reg),
            .sample     (sample[i]),
            .value_next (lane_value[i])
        );
    end

    isd_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .frame_ok   (s_tuser),
        .temp_raw   (s_tdata[95:80]),
        .stamp      (s_tdata[31:0]),
        .poll       (poll),
        .lane_value (lane_value),
        .s_ready    (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

>>> rtl/core/isd_checker.sv
// Port-level checks for the IMU smoothing decimator, bound to the top level.
`timescale 1ns / 1ps

module isd_checker
    import isd_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [ISD_S_TDATA_W-1:0]  s_tdata,
    input logic                      s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [ISD_M_TDATA_W-1:0]  m_tdata,
    input logic                      m_tuser,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [ISD_CFG_IDX_W-1:0]  cfg_index,
    input logic [ISD_WORD_W-1:0]     cfg_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stage");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without an accepted request");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind imu_six_axis_smoothing_decimator isd_checker u_isd_checker (.*);
